### rtl/timed_event_queue_assert.svh
// Assertion macros for the timed event queue
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH
// same-cycle implication, off during reset
`define TEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed_event_queue check failed");
// next-cycle implication, also active in reset
`define TEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("timed_event_queue check failed");
`endif

### rtl/tequ_pkg.sv
// Shared types and constants for the timed event queue
`timescale 1ns / 1ps
package tequ_pkg;
  localparam int POOL_SIZE_DEF = 32;
  localparam int OUT_LIMIT = 32;
  localparam int EMIT_W = $clog2(OUT_LIMIT + 1);

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_SCHED      = 2'd0,
    OP_CANCEL     = 2'd1,
    OP_SERV_NORM  = 2'd2,
    OP_SERV_IFACE = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic [31:0] due;
    logic [7:0]  sender;
    logic [7:0]  kind;
    logic        iface;
    logic        anyk;
    logic [31:0] payload;
  } cmd_t;
endpackage

### rtl/timed_event_queue.sv
// Top level of the timed event queue
// channel | handshake         | beat
// in_     | start / busy      | one command, taken when start && !busy
// out_    | out_valid strobe  | one result per strobe, no back-pressure
// A command waits in a two-beat queue, then the pool engine works it.
// Schedule reads from the tail toward the head.
// A schedule into a full pool reads no entry and returns status full.
// Cancel and service sweep all live entries.
// The single-port pool memory (one read, one write a cycle) sets the pace of these sweeps.
// Reset empties the pool at once; busy is high only while the command queue is full.
`timescale 1ns / 1ps
module timed_event_queue #(
  parameter int POOL_SIZE = tequ_pkg::POOL_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_sender_id,
  input  logic [7:0]  in_event_kind,
  input  logic        in_to_interface_queue,
  input  logic        in_any_kind,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_sender,
  output logic [7:0]  out_kind,
  output logic [31:0] out_payload,
  output logic [31:0] out_due,
  output logic [5:0]  out_removed_count,
  output logic        out_last
);
  logic           cmd_valid, cmd_ready;
  tequ_pkg::cmd_t cmd;

  tequ_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_now_time, .in_delay, .in_sender_id, .in_event_kind,
    .in_to_interface_queue, .in_any_kind, .in_payload,
    .cmd_valid, .cmd_ready, .cmd
  );

  tequ_back #(.POOL_SIZE(POOL_SIZE)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_status, .out_sender, .out_kind, .out_payload,
    .out_due, .out_removed_count, .out_last
  );
endmodule

### rtl/tequ_front.sv
// Command front end: decode, due-time add and a two-beat command queue
`timescale 1ns / 1ps
module tequ_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_now_time,
  input  logic [31:0]       in_delay,
  input  logic [7:0]        in_sender_id,
  input  logic [7:0]        in_event_kind,
  input  logic              in_to_interface_queue,
  input  logic              in_any_kind,
  input  logic [31:0]       in_payload,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output tequ_pkg::cmd_t    cmd
);
  tequ_pkg::cmd_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic [32:0]    sum;
  tequ_pkg::cmd_t c_in;
  logic           push, pop;

  always_comb begin
    sum = {1'b0, in_now_time} + {1'b0, in_delay};
    c_in.op = tequ_pkg::op_e'(in_action);
    c_in.now = in_now_time;
    c_in.due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    c_in.sender = in_sender_id;
    c_in.kind = in_event_kind;
    c_in.iface = in_to_interface_queue;
    c_in.anyk = in_any_kind;
    c_in.payload = in_payload;
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/tequ_back.sv
// Pool engine: sorted insert, cancel compaction and due-entry service
`timescale 1ns / 1ps
module tequ_back #(
  parameter int POOL_SIZE = tequ_pkg::POOL_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tequ_pkg::cmd_t    cmd,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [7:0]        out_sender,
  output logic [7:0]        out_kind,
  output logic [31:0]       out_payload,
  output logic [31:0]       out_due,
  output logic [5:0]        out_removed_count,
  output logic              out_last
);
  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int EW = tequ_pkg::EMIT_W;

  typedef struct packed {
    logic [31:0] due;
    logic [7:0]  sender;
    logic [7:0]  kind;
    logic [31:0] payload;
    logic        iface;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_WNEW, S_FIN} state_e;

  entry_t         mem [POOL_SIZE];
  entry_t         rd_r;
  state_e         state_r;
  tequ_pkg::cmd_t cmd_r;
  logic [CNT_W-1:0] cnt_r, i_r, w_r, rem_r;
  logic [EW-1:0]  emit_r;
  logic           stop_r, pend_v_r, full_r;
  entry_t         pend_r;

  logic           out_valid_r, out_last_r;
  logic [1:0]     out_status_r;
  logic [7:0]     out_sender_r, out_kind_r;
  logic [31:0]    out_payload_r, out_due_r;
  logic [5:0]     out_rem_r;

  entry_t         new_ent;
  logic           wr_en, gt, hit, want, match, take, at_end;
  logic [IDX_W-1:0] wr_addr;
  entry_t         wr_data;
  logic [CNT_W-1:0] i_inc;

  always_comb begin
    new_ent.due = cmd_r.due;
    new_ent.sender = cmd_r.sender;
    new_ent.kind = cmd_r.kind;
    new_ent.payload = cmd_r.payload;
    new_ent.iface = cmd_r.iface;
    i_inc = i_r + CNT_W'(1);
    at_end = (i_inc == cnt_r);
    gt = rd_r.due > cmd_r.due;
    hit = !rd_r.iface && (rd_r.sender == cmd_r.sender) &&
          (cmd_r.anyk || (rd_r.kind == cmd_r.kind));
    want = (cmd_r.op == tequ_pkg::OP_SERV_IFACE);
    match = !stop_r && (rd_r.iface == want);
    take = match && (rd_r.due <= cmd_r.now) && (emit_r < EW'(tequ_pkg::OUT_LIMIT));
    wr_en = 1'b0;
    wr_addr = w_r[IDX_W-1:0];
    wr_data = rd_r;
    if (state_r == S_WNEW) begin
      wr_en = 1'b1;
      wr_data = new_ent;
    end else if (state_r == S_PROC) begin
      unique case (cmd_r.op)
        tequ_pkg::OP_SCHED: begin
          wr_en = 1'b1;
          wr_addr = i_inc[IDX_W-1:0];
          wr_data = gt ? rd_r : new_ent;
        end
        tequ_pkg::OP_CANCEL: wr_en = !hit;
        default: wr_en = !take;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_r == S_RD) rd_r <= mem[i_r[IDX_W-1:0]];
  end

  assign cmd_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (cmd_valid) begin
            cmd_r <= cmd;
            i_r <= (cmd.op == tequ_pkg::OP_SCHED) ? cnt_r - CNT_W'(1) : '0;
            w_r <= '0;
            rem_r <= '0;
            emit_r <= '0;
            stop_r <= 1'b0;
            pend_v_r <= 1'b0;
            full_r <= (cmd.op == tequ_pkg::OP_SCHED) && (cnt_r == CNT_W'(POOL_SIZE));
            if (cmd.op == tequ_pkg::OP_SCHED) begin
              if (cnt_r == CNT_W'(POOL_SIZE)) begin
                state_r <= S_FIN;
              end else if (cnt_r == '0) begin
                state_r <= S_WNEW;
              end else begin
                state_r <= S_RD;
              end
            end else begin
              state_r <= (cnt_r == '0) ? S_FIN : S_RD;
            end
          end
        end
        S_RD: begin
          out_valid_r <= 1'b0;
          state_r <= S_PROC;
        end
        S_PROC: begin
          out_valid_r <= (cmd_r.op == tequ_pkg::OP_SERV_NORM ||
                          cmd_r.op == tequ_pkg::OP_SERV_IFACE) && take && pend_v_r;
          unique case (cmd_r.op)
            tequ_pkg::OP_SCHED: begin
              if (gt) begin
                if (i_r == '0) begin
                  w_r <= '0;
                  state_r <= S_WNEW;
                end else begin
                  i_r <= i_r - CNT_W'(1);
                  state_r <= S_RD;
                end
              end else begin
                cnt_r <= cnt_r + CNT_W'(1);
                state_r <= S_FIN;
              end
            end
            tequ_pkg::OP_CANCEL: begin
              if (hit) rem_r <= rem_r + CNT_W'(1);
              else w_r <= w_r + CNT_W'(1);
              i_r <= i_inc;
              if (at_end) begin
                cnt_r <= hit ? w_r : w_r + CNT_W'(1);
                state_r <= S_FIN;
              end else begin
                state_r <= S_RD;
              end
            end
            default: begin
              if (match && !take) stop_r <= 1'b1;
              if (take) begin
                if (pend_v_r) begin
                  out_status_r <= tequ_pkg::ST_EMIT;
                  out_sender_r <= pend_r.sender;
                  out_kind_r <= pend_r.kind;
                  out_payload_r <= pend_r.payload;
                  out_due_r <= pend_r.due;
                  out_rem_r <= '0;
                  out_last_r <= 1'b0;
                end
                pend_r <= rd_r;
                pend_v_r <= 1'b1;
                emit_r <= emit_r + EW'(1);
              end else begin
                w_r <= w_r + CNT_W'(1);
              end
              i_r <= i_inc;
              if (at_end) begin
                cnt_r <= take ? w_r : w_r + CNT_W'(1);
                state_r <= S_FIN;
              end else begin
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_WNEW: begin
          out_valid_r <= 1'b0;
          cnt_r <= cnt_r + CNT_W'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_last_r <= 1'b1;
          unique case (cmd_r.op)
            tequ_pkg::OP_SCHED: begin
              out_status_r <= full_r ? tequ_pkg::ST_FULL : tequ_pkg::ST_DONE;
              out_sender_r <= '0;
              out_kind_r <= '0;
              out_payload_r <= '0;
              out_due_r <= cmd_r.due;
              out_rem_r <= '0;
            end
            tequ_pkg::OP_CANCEL: begin
              out_status_r <= tequ_pkg::ST_DONE;
              out_sender_r <= '0;
              out_kind_r <= '0;
              out_payload_r <= '0;
              out_due_r <= '0;
              out_rem_r <= (32'(rem_r) > 32'd63) ? 6'd63 : 6'(rem_r);
            end
            default: begin
              out_status_r <= pend_v_r ? tequ_pkg::ST_EMIT : tequ_pkg::ST_NONE;
              out_sender_r <= pend_v_r ? pend_r.sender : '0;
              out_kind_r <= pend_v_r ? pend_r.kind : '0;
              out_payload_r <= pend_v_r ? pend_r.payload : '0;
              out_due_r <= pend_v_r ? pend_r.due : '0;
              out_rem_r <= '0;
            end
          endcase
          pend_v_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_sender = out_sender_r;
  assign out_kind = out_kind_r;
  assign out_payload = out_payload_r;
  assign out_due = out_due_r;
  assign out_removed_count = out_rem_r;
  assign out_last = out_last_r;
endmodule

### rtl/tequ_checker.sv
// Port-level checks for the timed event queue, bound to the top level
`timescale 1ns / 1ps
`include "timed_event_queue_assert.svh"
module tequ_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_sender,
  input logic [7:0]  out_kind,
  input logic [31:0] out_payload,
  input logic [5:0]  out_removed_count,
  input logic        out_last
);
  `TEQ_ASSERT_NXT(a_reset_quiet, !rst_n, !out_valid && !busy)
  `TEQ_ASSERT_NOW(a_single_last, out_valid && out_status != tequ_pkg::ST_EMIT, out_last)
  `TEQ_ASSERT_NOW(a_plain_zero, out_valid && out_status != tequ_pkg::ST_EMIT, out_sender == 8'd0 && out_kind == 8'd0 && out_payload == 32'd0)
  `TEQ_ASSERT_NOW(a_rem_cancel, out_valid && out_status != tequ_pkg::ST_DONE, out_removed_count == 6'd0)
endmodule

bind timed_event_queue tequ_checker u_chk (.*);

### test/timed_event_queue_tb.sv
// Testbench for the timed event queue: random and directed commands checked against a model
`timescale 1ns / 1ps
module timed_event_queue_tb;

  class event_scoreboard;
    logic [31:0] pool_due[$];
    logic [7:0]  pool_sender[$];
    logic [7:0]  pool_kind[$];
    logic [31:0] pool_payload[$];
    logic        pool_iface[$];
    logic [1:0]  exp_status[$];
    logic [7:0]  exp_sender[$];
    logic [7:0]  exp_kind[$];
    logic [31:0] exp_payload[$];
    logic [31:0] exp_due[$];
    logic [5:0]  exp_removed[$];
    logic        exp_last[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void push_result(logic [1:0] st, logic [7:0] s, logic [7:0] k,
                              logic [31:0] p, logic [31:0] d, logic [5:0] r, logic l);
      exp_status.push_back(st);
      exp_sender.push_back(s);
      exp_kind.push_back(k);
      exp_payload.push_back(p);
      exp_due.push_back(d);
      exp_removed.push_back(r);
      exp_last.push_back(l);
    endfunction

    function void drop_entry(int i);
      pool_due.delete(i);
      pool_sender.delete(i);
      pool_kind.delete(i);
      pool_payload.delete(i);
      pool_iface.delete(i);
    endfunction

    function void note_command(tequ_pkg::op_e op, logic [31:0] now, logic [31:0] dly,
                               logic [7:0] snd, logic [7:0] knd, logic ifc, logic anyk,
                               logic [31:0] pay);
      logic [32:0] sum;
      logic [31:0] due;
      int pos, i, removed, emitted;
      logic stop;
      if (op == tequ_pkg::OP_SCHED) begin
        sum = {1'b0, now} + {1'b0, dly};
        due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (pool_due.size() >= 32) begin
          push_result(tequ_pkg::ST_FULL, 0, 0, 0, due, 0, 1);
          return;
        end
        pos = 0;
        while (pos < pool_due.size() && pool_due[pos] <= due) pos++;
        pool_due.insert(pos, due);
        pool_sender.insert(pos, snd);
        pool_kind.insert(pos, knd);
        pool_payload.insert(pos, pay);
        pool_iface.insert(pos, ifc);
        push_result(tequ_pkg::ST_DONE, 0, 0, 0, due, 0, 1);
      end else if (op == tequ_pkg::OP_CANCEL) begin
        removed = 0;
        i = 0;
        while (i < pool_due.size()) begin
          if (!pool_iface[i] && pool_sender[i] == snd && (anyk || pool_kind[i] == knd)) begin
            drop_entry(i);
            removed++;
          end else begin
            i++;
          end
        end
        push_result(tequ_pkg::ST_DONE, 0, 0, 0, 0, removed, 1);
      end else begin
        emitted = 0;
        stop = 0;
        i = 0;
        while (i < pool_due.size()) begin
          if (!stop && pool_iface[i] == (op == tequ_pkg::OP_SERV_IFACE)) begin
            if (pool_due[i] <= now && emitted < 32) begin
              push_result(tequ_pkg::ST_EMIT, pool_sender[i], pool_kind[i], pool_payload[i],
                          pool_due[i], 0, 0);
              emitted++;
              drop_entry(i);
              continue;
            end
            stop = 1;
          end
          i++;
        end
        if (emitted == 0) push_result(tequ_pkg::ST_NONE, 0, 0, 0, 0, 0, 1);
        else exp_last[exp_last.size() - 1] = 1;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] s, logic [7:0] k, logic [31:0] p,
                               logic [31:0] d, logic [5:0] r, logic l);
      if (exp_status.size() == 0) begin
        $display("%0t unexpected result status %0d", $realtime, st);
        errors++;
        return;
      end
      if (st !== exp_status[0] || s !== exp_sender[0] || k !== exp_kind[0] ||
          p !== exp_payload[0] || d !== exp_due[0] || r !== exp_removed[0] ||
          l !== exp_last[0]) begin
        $display("%0t mismatch expected st=%0d snd=%h knd=%h pay=%h due=%h rem=%0d last=%b",
                 $realtime, exp_status[0], exp_sender[0], exp_kind[0], exp_payload[0],
                 exp_due[0], exp_removed[0], exp_last[0]);
        $display("%0t          actual   st=%0d snd=%h knd=%h pay=%h due=%h rem=%0d last=%b",
                 $realtime, st, s, k, p, d, r, l);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_sender.pop_front());
      void'(exp_kind.pop_front());
      void'(exp_payload.pop_front());
      void'(exp_due.pop_front());
      void'(exp_removed.pop_front());
      void'(exp_last.pop_front());
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0] in_action;
  logic [31:0] in_now_time, in_delay, in_payload;
  logic [7:0] in_sender_id, in_event_kind;
  logic in_to_interface_queue, in_any_kind;
  logic out_valid, out_last;
  logic [1:0] out_status;
  logic [7:0] out_sender, out_kind;
  logic [31:0] out_payload, out_due;
  logic [5:0] out_removed_count;

  event_scoreboard board;
  int idle_cycles;
  logic [31:0] clock_now;

  timed_event_queue DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_action = tequ_pkg::OP_SCHED;
    in_now_time = 0;
    in_delay = 0;
    in_sender_id = 0;
    in_event_kind = 0;
    in_to_interface_queue = 0;
    in_any_kind = 0;
    in_payload = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        board.check_result(out_status, out_sender, out_kind, out_payload, out_due,
                           out_removed_count, out_last);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("timed_event_queue_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_command(tequ_pkg::op_e op, logic [31:0] now, logic [31:0] dly,
                              logic [7:0] snd, logic [7:0] knd, logic ifc, logic anyk,
                              logic [31:0] pay);
    start <= 1;
    in_action <= op;
    in_now_time <= now;
    in_delay <= dly;
    in_sender_id <= snd;
    in_event_kind <= knd;
    in_to_interface_queue <= ifc;
    in_any_kind <= anyk;
    in_payload <= pay;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(op, now, dly, snd, knd, ifc, anyk, pay);
  endtask

  task automatic pause_sender();
    start <= 0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  task automatic random_command();
    int r;
    logic [31:0] dly;
    r = $urandom_range(0, 99);
    dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
    if ($urandom_range(0, 15) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 20);
    if (r < 50)
      send_command(tequ_pkg::OP_SCHED, clock_now, dly, $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom);
    else if (r < 65)
      send_command(tequ_pkg::OP_CANCEL, clock_now, $urandom,
                   ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3),
                   $urandom_range(0, 3), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom);
    else
      send_command(r < 83 ? tequ_pkg::OP_SERV_NORM : tequ_pkg::OP_SERV_IFACE, clock_now,
                   $urandom, $urandom, $urandom, $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom);
  endtask

  initial begin
    int n, burst;
    board = new();
    idle_cycles = 0;
    clock_now = 100;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_command(tequ_pkg::OP_SERV_NORM, 0, 0, 0, 0, 0, 0, 0);
    send_command(tequ_pkg::OP_SERV_IFACE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_command(tequ_pkg::OP_SCHED, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0, 1,
                 32'hFFFF_FFFF);
    send_command(tequ_pkg::OP_SCHED, 5, 0, 8'h00, 8'h00, 1, 0, 32'h0);
    send_command(tequ_pkg::OP_SCHED, 5, 0, 8'h01, 8'h02, 0, 0, 32'hA5A5_5A5A);
    send_command(tequ_pkg::OP_SCHED, 5, 0, 8'h01, 8'h03, 1, 0, 32'h1234_5678);
    send_command(tequ_pkg::OP_CANCEL, 0, 0, 8'h01, 8'h00, 0, 1, 0);
    send_command(tequ_pkg::OP_CANCEL, 0, 0, 8'hFF, 8'hFF, 1, 0, 0);
    for (n = 0; n < 34; n++)
      send_command(tequ_pkg::OP_SCHED, 10, n % 3, 8'h07, n[7:0], n[0], 0, n);
    send_command(tequ_pkg::OP_SERV_IFACE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_command(tequ_pkg::OP_SERV_NORM, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_command(tequ_pkg::OP_SERV_NORM, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_command(tequ_pkg::OP_SERV_IFACE, 0, 0, 0, 0, 0, 0, 0);
    n = 0;
    while (n < 174) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_command();
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    start <= 0;
    while (board.exp_status.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.exp_status.size() == 0) begin
      $display("timed_event_queue_tb OK");
    end else begin
      $display("timed_event_queue_tb NOT OK");
    end
    $finish;
  end
endmodule
